[rtl/lii_pkg.sv]
// Shared types, codes and sizes for the piecewise linear interpolation block.
// No dependencies; imported by every module of the block.
`default_nettype none
package lii_pkg;

    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_INTERP = 2'd1;
    localparam logic [1:0] FUNC_INTEG  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NONINC   = 2'd2;
    localparam logic [1:0] ST_FEW      = 2'd3;

    typedef struct packed {
        logic signed [31:0] y;
        logic signed [31:0] x;
    } lii_entry_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         point_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] query_z;
    } lii_item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        lii_entry_t        data;
    } lii_wr_t;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         status;
    } lii_res_t;

endpackage
`default_nettype wire

[rtl/lii_table.sv]
// Breakpoint store: one write port, one read port, registered read data.
// Depends on lii_pkg.
`default_nettype none
module lii_table (
    input  wire                        aclk,
    input  lii_pkg::lii_wr_t           wr,
    input  wire [lii_pkg::ADDR_W-1:0]  rd_addr,
    output lii_pkg::lii_entry_t        rd_data
);
    import lii_pkg::*;

    lii_entry_t mem [MAX_POINTS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[rtl/lii_div.sv]
// Restoring divider, one quotient bit per cycle, 64 by 32 bits with a 32-bit quotient.
// Caller guarantees the quotient fits. Depends on lii_pkg.
`default_nettype none
module lii_div (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire [63:0]  dividend,
    input  wire [31:0]  divisor,
    output logic        done,
    output logic [31:0] quotient
);
    import lii_pkg::*;

    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial    = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == 5'd31);
            if (start) begin
                rem_reg  <= dividend[63:32];
                quo_reg  <= dividend[31:0];
                dvs_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (!trial[32]) begin
                    rem_reg <= trial[31:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[30:0], quo_reg[31]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/lii_core.sv]
// Sequencer: table reads, binary search, trapezoid walk, multiply and accumulate.
// Depends on lii_pkg; drives lii_table and lii_div.
`default_nettype none
module lii_core (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  lii_pkg::lii_item_t         in_item,
    input  wire [lii_pkg::CNT_W-1:0]   n_in,
    output lii_pkg::lii_wr_t           wr,
    output logic [lii_pkg::ADDR_W-1:0] rd_addr,
    input  lii_pkg::lii_entry_t        rd_data,
    output logic                       div_start,
    output logic [63:0]                div_dividend,
    output logic [31:0]                div_divisor,
    input  wire                        div_done,
    input  wire [31:0]                 div_quotient,
    output logic                       res_valid,
    input  wire                        res_ready,
    output lii_pkg::lii_res_t          res
);
    import lii_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK0, S_CHK1, S_SRCH, S_PA, S_PB, S_MUL,
        S_DIVST, S_DIVW, S_AMUL, S_ACC, S_DONE
    } state_t;

    state_t             state_reg;
    logic [1:0]         func_reg;
    logic signed [31:0] z_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [ADDR_W-1:0]  i_reg, j_reg, mid_reg;
    logic signed [31:0] xa_reg, ya_reg, xb_reg, yb_reg, yz_reg;
    logic [63:0]        prod_reg;
    logic               sgn_reg;
    logic               part_reg;
    logic signed [63:0] acc_reg;
    lii_res_t           res_reg;

    logic [ADDR_W-1:0]  last_idx, srch_i, srch_j, srch_mid;
    logic [ADDR_W:0]    mid_sum;
    logic               more_srch;
    logic signed [32:0] dy33, s33, t33, dx33;
    logic [32:0]        abs_dy, abs_s, op_a;
    logic [31:0]        op_b;
    logic [64:0]        prod65;
    logic [63:0]        area;
    logic [64:0]        sum65;
    logic signed [63:0] acc_sat;
    logic [33:0]        term34, yz34;
    logic               cont;
    logic               few_pts;

    assign last_idx  = ADDR_W'(n_reg - CNT_W'(1));
    assign srch_i    = (z_reg > rd_data.x) ? mid_reg : i_reg;
    assign srch_j    = (z_reg > rd_data.x) ? j_reg : mid_reg;
    assign mid_sum   = {1'b0, srch_i} + {1'b0, srch_j};
    assign srch_mid  = mid_sum[ADDR_W:1];
    assign more_srch = (srch_j - srch_i) > ADDR_W'(1);
    assign cont      = (func_reg == FUNC_INTEG) && ({1'b0, i_reg} < n_reg - CNT_W'(2))
                       && (z_reg > rd_data.x);
    assign few_pts   = ((in_item.func == FUNC_INTERP) || (in_item.func == FUNC_INTEG))
                       && (n_in < CNT_W'(2));

    assign dy33   = {yb_reg[31], yb_reg} - {ya_reg[31], ya_reg};
    assign s33    = {ya_reg[31], ya_reg} + (part_reg ? {yz_reg[31], yz_reg}
                                                     : {yb_reg[31], yb_reg});
    assign t33    = {z_reg[31], z_reg} - {xa_reg[31], xa_reg};
    assign dx33   = {xb_reg[31], xb_reg} - {xa_reg[31], xa_reg};
    assign abs_dy = dy33[32] ? 33'(-dy33) : 33'(dy33);
    assign abs_s  = s33[32] ? 33'(-s33) : 33'(s33);
    assign op_a   = (state_reg == S_MUL) ? abs_dy : abs_s;
    assign op_b   = ((state_reg == S_MUL) || part_reg) ? t33[31:0] : dx33[31:0];
    assign prod65 = op_a * {1'b0, op_b};

    assign area    = sgn_reg ? -{17'b0, prod_reg[63:17]} : {17'b0, prod_reg[63:17]};
    assign sum65   = {acc_reg[63], acc_reg} + {area[63], area};
    assign acc_sat = (sum65[64] != sum65[63])
                     ? (sum65[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}})
                     : sum65[63:0];

    assign term34 = sgn_reg ? -{2'b0, div_quotient} : {2'b0, div_quotient};
    assign yz34   = {{2{ya_reg[31]}}, ya_reg} + term34;

    assign in_ready     = (state_reg == S_IDLE);
    assign res_valid    = (state_reg == S_DONE);
    assign res          = res_reg;
    assign div_start    = (state_reg == S_DIVST);
    assign div_dividend = prod_reg;
    assign div_divisor  = dx33[31:0];

    always_comb begin
        wr.en   = (state_reg == S_IDLE) && in_valid && (in_item.func == FUNC_LOAD);
        wr.addr = ADDR_W'(in_item.point_index);
        wr.data = '{y: in_item.point_y, x: in_item.point_x};
    end

    always_comb begin
        rd_addr = '0;
        case (state_reg)
            S_CHK0: rd_addr = last_idx;
            S_CHK1: begin
                if ((func_reg == FUNC_INTERP) && (last_idx > ADDR_W'(1))) begin
                    rd_addr = ADDR_W'(last_idx >> 1);
                end
            end
            S_SRCH: rd_addr = more_srch ? srch_mid : srch_i;
            S_PA:   rd_addr = i_reg + ADDR_W'(1);
            S_ACC:  rd_addr = i_reg + ADDR_W'(2);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        func_reg <= in_item.func;
                        z_reg    <= in_item.query_z;
                        n_reg    <= n_in;
                        acc_reg  <= '0;
                        part_reg <= 1'b0;
                        res_reg  <= '{result_value: '0, status: few_pts ? ST_FEW : ST_OK};
                        if ((in_item.func == FUNC_INTERP) || (in_item.func == FUNC_INTEG)) begin
                            if (few_pts) begin
                                state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_CHK0;
                            end
                        end else begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_CHK0: begin
                    if (z_reg < rd_data.x) begin
                        res_reg.status <= ST_RANGE;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_CHK1;
                    end
                end
                S_CHK1: begin
                    i_reg <= '0;
                    j_reg <= last_idx;
                    if (z_reg > rd_data.x) begin
                        res_reg.status <= ST_RANGE;
                        state_reg      <= S_DONE;
                    end else if ((func_reg == FUNC_INTERP) && (last_idx > ADDR_W'(1))) begin
                        mid_reg   <= ADDR_W'(last_idx >> 1);
                        state_reg <= S_SRCH;
                    end else begin
                        state_reg <= S_PA;
                    end
                end
                S_SRCH: begin
                    i_reg   <= srch_i;
                    j_reg   <= srch_j;
                    mid_reg <= srch_mid;
                    if (!more_srch) begin
                        state_reg <= S_PA;
                    end
                end
                S_PA: begin
                    xa_reg    <= rd_data.x;
                    ya_reg    <= rd_data.y;
                    state_reg <= S_PB;
                end
                S_PB: begin
                    xb_reg <= rd_data.x;
                    yb_reg <= rd_data.y;
                    if (rd_data.x <= xa_reg) begin
                        res_reg.status <= ST_NONINC;
                        state_reg      <= S_DONE;
                    end else if (cont) begin
                        state_reg <= S_AMUL;
                    end else if (z_reg < xa_reg) begin
                        res_reg.status <= ST_NONINC;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    prod_reg  <= prod65[63:0];
                    sgn_reg   <= dy33[32];
                    state_reg <= S_DIVST;
                end
                S_DIVST: begin
                    state_reg <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_done) begin
                        if (func_reg == FUNC_INTERP) begin
                            res_reg.result_value <= 64'(signed'(yz34));
                            state_reg            <= S_DONE;
                        end else begin
                            yz_reg    <= yz34[31:0];
                            part_reg  <= 1'b1;
                            state_reg <= S_AMUL;
                        end
                    end
                end
                S_AMUL: begin
                    prod_reg  <= prod65[63:0];
                    sgn_reg   <= s33[32];
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= acc_sat;
                    if (part_reg) begin
                        res_reg.result_value <= acc_sat;
                        state_reg            <= S_DONE;
                    end else begin
                        i_reg     <= i_reg + ADDR_W'(1);
                        xa_reg    <= xb_reg;
                        ya_reg    <= yb_reg;
                        state_reg <= S_PB;
                    end
                end
                S_DONE: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/linear_interp_and_integral.sv]
// Load, no-op and too-few-points items go from idle straight to the result state; interpolate
// runs range checks, a binary search, a multiply and the 32-step divider, using the read port.
// Integrate walks the full intervals, one read per interval, then divides for the partial one.
// Items are handled one at a time; the next item is taken once the result is in the
// output register. Reset clears control and the output valid flag and sets point_count to 2;
// table contents stay undefined until written, with no clearing pass.
`default_nettype none
module linear_interp_and_integral (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [103:0]  s_tdata,   // point_index, point_x, point_y, query_z
    input  wire [1:0]    s_tuser,   // func
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [63:0]  m_tdata,   // result_value
    output logic [1:0]   m_tuser,   // status
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire [8:0]    cfg_data   // point_count
);
    import lii_pkg::*;

    logic [CNT_W-1:0]  pcount_reg;
    logic [CNT_W-1:0]  n_use;
    logic              m_tvalid_reg;
    lii_res_t          m_res_reg;
    lii_item_t         item;
    lii_wr_t           wr;
    logic [ADDR_W-1:0] rd_addr;
    lii_entry_t        rd_data;
    logic              div_start, div_done;
    logic [63:0]       div_dividend;
    logic [31:0]       div_divisor, div_quotient;
    logic              res_valid, res_ready;
    lii_res_t          res;

    assign item.func        = s_tuser;
    assign item.point_index = s_tdata[7:0];
    assign item.point_x     = s_tdata[39:8];
    assign item.point_y     = s_tdata[71:40];
    assign item.query_z     = s_tdata[103:72];

    assign n_use     = (pcount_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pcount_reg;
    assign cfg_ready = 1'b1;
    assign res_ready = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_res_reg.result_value;
    assign m_tuser   = m_res_reg.status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcount_reg   <= CNT_W'(2);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                pcount_reg <= CNT_W'(cfg_data);
            end
            if (res_valid && res_ready) begin
                m_tvalid_reg <= 1'b1;
                m_res_reg    <= res;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    lii_table u_table (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lii_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    lii_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_item      (item),
        .n_in         (n_use),
        .wr           (wr),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quotient (div_quotient),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

endmodule
`default_nettype wire

[rtl/lii_checker.sv]
// Port-level checks for linear_interp_and_integral, attached by bind.
// Depends on lii_pkg for status codes.
`default_nettype none
module lii_checker (
    input wire         aclk,
    input wire         aresetn,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [63:0]  m_tdata,
    input wire [1:0]   m_tuser
);
    import lii_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> m_tdata == 64'd0)
        else $error("error result carries a value");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind linear_interp_and_integral lii_checker u_lii_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for linear_interp_and_integral: loads breakpoint tables,
// runs interpolate and integrate queries under random stalls, checks every result.
// Depends on rtl/lii_pkg.sv and rtl/linear_interp_and_integral.sv.
`timescale 1ns / 1ps
module testbench;
    import lii_pkg::*;

    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int STALL_LIMIT      = 20000;
    localparam int HOLD_START       = 3000;
    localparam int HOLD_END         = 3400;
    localparam int QUIET_START      = 6000;
    localparam int QUIET_END        = 9000;
    localparam longint I64_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN      = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    typedef struct {
        longint     value;
        logic [1:0] status;
    } interp_res_t;

    class interp_scoreboard;
        longint      x_tab[MAX_POINTS];
        longint      y_tab[MAX_POINTS];
        int          count_reg;
        interp_res_t pending[$];
        int          errors;

        function new();
            count_reg = 2;
            errors    = 0;
            foreach (x_tab[i]) begin
                x_tab[i] = 0;
                y_tab[i] = 0;
            end
        endfunction

        function int points_used();
            return (count_reg > MAX_POINTS) ? MAX_POINTS : count_reg;
        endfunction

        function longint sat_sum(longint a, longint b);
            if (b > 0 && a > I64_MAX - b) return I64_MAX;
            if (b < 0 && a < I64_MIN - b) return I64_MIN;
            return a + b;
        endfunction

        function longint value_at(int i, longint z);
            longint     dy;
            bit [63:0]  dx, t, mag, q;
            dy  = y_tab[i+1] - y_tab[i];
            dx  = x_tab[i+1] - x_tab[i];
            t   = z - x_tab[i];
            mag = (dy < 0) ? -dy : dy;
            q   = (mag * t) / dx;
            return y_tab[i] + ((dy < 0) ? -longint'(q) : longint'(q));
        endfunction

        function longint trapezoid(longint a, longint b, bit [63:0] w);
            longint    s;
            bit [63:0] mag, q;
            s   = a + b;
            mag = (s < 0) ? -s : s;
            q   = (mag * w) >> 17;
            return (s < 0) ? -longint'(q) : longint'(q);
        endfunction

        function void note_item(lii_item_t it);
            interp_res_t r;
            longint      z, acc;
            int          n, i, j, mid;
            bit          bad;
            z        = longint'(it.query_z);
            n        = points_used();
            r.value  = 0;
            r.status = ST_OK;
            if (it.func == FUNC_LOAD) begin
                x_tab[it.point_index] = longint'(it.point_x);
                y_tab[it.point_index] = longint'(it.point_y);
            end else if (it.func == FUNC_INTERP || it.func == FUNC_INTEG) begin
                if (n < 2) begin
                    r.status = ST_FEW;
                end else if (z < x_tab[0] || z > x_tab[n-1]) begin
                    r.status = ST_RANGE;
                end else if (it.func == FUNC_INTERP) begin
                    i = 0;
                    j = n - 1;
                    while (j - i > 1) begin
                        mid = (i + j) / 2;
                        if (z > x_tab[mid]) i = mid;
                        else j = mid;
                    end
                    if (x_tab[i+1] <= x_tab[i]) r.status = ST_NONINC;
                    else r.value = value_at(i, z);
                end else begin
                    i   = 0;
                    acc = 0;
                    bad = 0;
                    while (i < n - 2 && z > x_tab[i+1] && !bad) begin
                        if (x_tab[i+1] <= x_tab[i]) begin
                            bad = 1;
                        end else begin
                            acc = sat_sum(acc, trapezoid(y_tab[i], y_tab[i+1],
                                          x_tab[i+1] - x_tab[i]));
                            i++;
                        end
                    end
                    if (bad || x_tab[i+1] <= x_tab[i] || z < x_tab[i]) begin
                        r.status = ST_NONINC;
                    end else begin
                        acc = sat_sum(acc, trapezoid(y_tab[i], value_at(i, z),
                                      z - x_tab[i]));
                        r.value = acc;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [63:0] data, logic [1:0] stat);
            interp_res_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h status %0d", data, stat);
                return;
            end
            e = pending.pop_front();
            if (data !== e.value || stat !== e.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h status %0d, got %h status %0d",
                             e.value, e.status, data, stat);
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [8:0]   cfg_data = '0;

    interp_scoreboard sb = new();
    int  cyc = 0;
    int  stall = 0;
    int  sent = 0;
    bit  quiet;

    assign quiet = (cyc >= QUIET_START && cyc < QUIET_END);

    linear_interp_and_integral dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= HOLD_START && cyc < HOLD_END) m_tready <= 1'b0;
        else if (quiet) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) >= 10);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall <= 0;
        end else if (stall >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            stall <= stall + 1;
        end
    end

    task automatic send(logic [1:0] f, int idx, longint px, longint py, longint z);
        lii_item_t it;
        it.func        = f;
        it.point_index = idx[7:0];
        it.point_x     = px[31:0];
        it.point_y     = py[31:0];
        it.query_z     = z[31:0];
        s_tuser  <= f;
        s_tdata  <= {it.query_z, it.point_y, it.point_x, it.point_index};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(it);
        sent++;
        if (!quiet && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic write_count(int v);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_data  <= v[8:0];
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.count_reg = v;
    endtask

    task automatic load_layout(int ne);
        longint cap, step, span, lo, x, y;
        int     k;
        cap  = 64'hFFFF_FFFF / (ne - 1);
        step = 1 + ((longint'($urandom) >> $urandom_range(0, 31)) % cap);
        span = step * (ne - 1);
        lo   = -64'sh8000_0000 + (longint'($urandom) % (64'h1_0000_0000 - span));
        k    = ($urandom_range(0, 5) == 0) ? $urandom_range(0, ne - 2) : -1;
        for (int i = 0; i < ne; i++) begin
            x = lo + i * step;
            if (step > 1 && i > 0 && i < ne - 1) x += longint'($urandom) % (step / 2);
            if (i == k + 1) x = sb.x_tab[k] - longint'($urandom_range(0, 3));
            if (x < -64'sh8000_0000) x = -64'sh8000_0000;
            y = $urandom_range(0, 1) ? longint'(int'($urandom))
                                     : longint'($urandom_range(0, 2097152)) - 1048576;
            send(FUNC_LOAD, i, x, y, longint'(int'($urandom)));
        end
    endtask

    task automatic random_query(int ne);
        longint z, a, b;
        int     r, k;
        logic [1:0] f;
        r = $urandom_range(0, 99);
        f = (r < 45) ? FUNC_INTERP : (r < 85) ? FUNC_INTEG : (r < 95) ? FUNC_LOAD : FUNC_NOP;
        if (f == FUNC_LOAD) begin
            send(f, $urandom_range(0, 255), longint'(int'($urandom)),
                 longint'(int'($urandom)), longint'(int'($urandom)));
            return;
        end
        z = longint'(int'($urandom));
        if (ne >= 2) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                k = $urandom_range(0, ne - 2);
                a = sb.x_tab[k];
                b = sb.x_tab[k+1];
                z = (b > a) ? a + longint'($urandom) % (b - a + 1) : a;
            end else if (r == 7) begin
                z = sb.x_tab[$urandom_range(0, ne - 1)];
            end else if (r == 8) begin
                if (sb.x_tab[0] > -64'sh8000_0000) z = sb.x_tab[0] - 1;
                else if (sb.x_tab[ne-1] < 64'sh7FFF_FFFF) z = sb.x_tab[ne-1] + 1;
            end
        end
        send(f, $urandom_range(0, 255), longint'(int'($urandom)),
             longint'(int'($urandom)), z);
    endtask

    initial begin
        int cnt, ne, len;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_count(2);
        send(FUNC_LOAD, 0, -65536, 64'sh7FFF_FFFF, 0);
        send(FUNC_LOAD, 1, 65536, -64'sh8000_0000, 0);
        send(FUNC_INTERP, 0, 0, 0, -65536);
        send(FUNC_INTERP, 0, 0, 0, 65536);
        send(FUNC_INTERP, 0, 0, 0, 0);
        send(FUNC_INTERP, 0, 0, 0, -65537);
        send(FUNC_INTERP, 0, 0, 0, 65537);
        send(FUNC_INTEG, 0, 0, 0, 0);
        send(FUNC_INTEG, 0, 0, 0, 65536);
        send(FUNC_INTEG, 0, 0, 0, -65537);
        send(FUNC_NOP, 255, -1, -1, -1);
        send(FUNC_LOAD, 0, -64'sh8000_0000, -64'sh8000_0000, 0);
        send(FUNC_LOAD, 1, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 0);
        send(FUNC_INTERP, 0, 0, 0, 0);
        send(FUNC_INTEG, 0, 0, 0, 64'sh7FFF_FFFF);
        send(FUNC_INTERP, 0, 0, 0, -64'sh8000_0000);
        send(FUNC_INTEG, 0, 0, 0, 64'sh4000_0000);
        send(FUNC_LOAD, 1, -64'sh8000_0000, 5, 0);
        send(FUNC_INTERP, 0, 0, 0, -64'sh8000_0000);
        send(FUNC_INTEG, 0, 0, 0, -64'sh8000_0000);
        write_count(0);
        send(FUNC_INTERP, 0, 0, 0, 0);
        write_count(1);
        send(FUNC_INTEG, 0, 0, 0, 0);

        write_count(256);
        load_layout(MAX_POINTS);
        repeat (40) random_query(MAX_POINTS);

        while (sent < 1750) begin
            case ($urandom_range(0, 15))
                0: cnt = 0;
                1: cnt = 1;
                2: cnt = 2;
                3: cnt = 256;
                4: cnt = $urandom_range(257, 510);
                5: cnt = 511;
                default: cnt = $urandom_range(3, 24);
            endcase
            write_count(cnt);
            ne = sb.points_used();
            if (ne >= 2 && ne <= 32) load_layout(ne);
            len = (ne > 32) ? $urandom_range(5, 15) : $urandom_range(20, 60);
            repeat (len) random_query(ne);
        end

        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
